// ----- rtl/core/sfpv_pkg.sv -----
// sfpv_pkg: shared types and constants of the sonar frame parser/validator
// no dependencies; used by sfpv_out_if, the front, queue and back modules

package sfpv_pkg;

  localparam int RANGE_W     = 16;
  localparam int SUM_W       = 20;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CMD_BYTE = 8'h55;
  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [1:0] LAST_IDX = 2'd3;

  localparam logic [RANGE_W-1:0] SPREAD_RESET = 16'd50;

  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_BAD  = 2'd2;
  localparam logic [1:0] OP_GOOD = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [RANGE_W-1:0] meas;
  } op_t;

endpackage

// ----- rtl/core/sfpv_if.sv -----
// sfpv_in_if, sfpv_out_if: valid/ready channels of the parser core
// depends on sfpv_pkg for field widths

interface sfpv_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source(output valid, func, rx_byte, input ready);
  modport sink(input valid, func, rx_byte, output ready);
endinterface

interface sfpv_out_if;
  logic                         valid;
  logic                         ready;
  logic                         send_valid;
  logic [7:0]                   send_byte;
  logic [sfpv_pkg::RANGE_W-1:0] range_value;
  logic                         fail_flag;
  logic                         frame_done;
  logic                         frame_good;
  modport source(output valid, send_valid, send_byte, range_value, fail_flag, frame_done,
                 frame_good, input ready);
  modport sink(input valid, send_valid, send_byte, range_value, fail_flag, frame_done,
               frame_good, output ready);
endinterface

// ----- rtl/core/sfpv_front.sv -----
// sfpv_front: accepts input transfers, assembles frames and classifies each item
// depends on sfpv_pkg and sfpv_in_if

module sfpv_front (
  input  logic          clk,
  input  logic          rst_n,
  sfpv_in_if.sink       in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output sfpv_pkg::op_t push_op
);

  logic [1:0] idx_r, idx_nxt;
  logic       ready_r, ready_nxt;
  logic [7:0] fb0_r, fb1_r, fb2_r;
  logic [7:0] frame_sum;
  logic       frame_ok;
  logic       acc;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign acc         = in_ch.valid && push_ready;

  assign frame_sum = fb0_r + fb1_r + fb2_r;
  assign frame_ok  = (fb0_r == sfpv_pkg::HDR_BYTE) && (frame_sum == in_ch.rx_byte);

  always_comb begin
    idx_nxt      = idx_r;
    ready_nxt    = ready_r;
    push_op.kind = sfpv_pkg::OP_NOP;
    push_op.meas = {fb1_r, fb2_r};
    if (in_ch.func) begin
      if (ready_r) begin
        push_op.kind = sfpv_pkg::OP_REQ;
        ready_nxt    = 1'b0;
      end
    end else if (idx_r != sfpv_pkg::LAST_IDX) begin
      idx_nxt = idx_r + 2'd1;
    end else begin
      push_op.kind = frame_ok ? sfpv_pkg::OP_GOOD : sfpv_pkg::OP_BAD;
      idx_nxt      = 2'd0;
      ready_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      ready_r <= 1'b1;
    end else if (acc) begin
      idx_r   <= idx_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_ch.func) begin
      case (idx_r)
        2'd0: fb0_r <= in_ch.rx_byte;
        2'd1: fb1_r <= in_ch.rx_byte;
        2'd2: fb2_r <= in_ch.rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/sfpv_queue.sv -----
// sfpv_queue: short fifo of classified items between front and back
// depends on sfpv_pkg for the entry type

module sfpv_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sfpv_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sfpv_pkg::op_t pop_op
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfpv_pkg::op_t  ent_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/core/sfpv_back.sv -----
// sfpv_back: applies classified items to range, fail and window state, drives results
// depends on sfpv_pkg and sfpv_out_if

module sfpv_back #(
  parameter int WINDOW_SIZE = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  sfpv_pkg::op_t                pop_op,
  input  logic                         cfg_we,
  input  logic [sfpv_pkg::RANGE_W-1:0] cfg_wdata,
  sfpv_out_if.source                   out_ch
);

  localparam int RW    = sfpv_pkg::RANGE_W;
  localparam int SW    = sfpv_pkg::SUM_W;
  localparam int CW    = sfpv_pkg::CNT_W;
  localparam int PW    = 2 * SW;
  localparam int RECIP = (1 << SW) / WINDOW_SIZE;
  localparam logic [CW-1:0] WIN = CW'(WINDOW_SIZE);

  logic [RW-1:0] limit_r;
  logic [RW-1:0] range_r, range_nxt;
  logic          fail_r, fail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [RW-1:0] min_r, min_nxt, max_r, max_nxt;
  logic          sum_wr, sum_fresh_r;
  logic [PW-1:0] prod_r;

  logic          out_valid_r;
  logic          send_valid_r;
  logic [RW-1:0] range_out_r;
  logic          fail_out_r, done_out_r, good_out_r;

  logic [RW-1:0] q_est, avg, hi, lo, eff_min, eff_max;
  logic [SW-1:0] rem;
  logic          check_fail, wait_avg, out_free, take, win_on;

  assign win_on   = (limit_r != '0);
  assign wait_avg = pop_valid && (pop_op.kind == sfpv_pkg::OP_GOOD) && win_on &&
                    (cnt_r == WIN) && sum_fresh_r;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = out_free && !wait_avg;
  assign take      = pop_valid && pop_ready;

  // average of the full window, reciprocal estimate plus one correction
  assign q_est = prod_r[SW +: RW];
  assign rem   = sum_r - SW'(q_est) * SW'(WINDOW_SIZE);
  assign avg   = (rem >= SW'(WINDOW_SIZE)) ? q_est + RW'(1) : q_est;
  assign hi    = (max_r >= avg) ? max_r - avg : '0;
  assign lo    = (avg >= min_r) ? avg - min_r : '0;
  assign check_fail = (hi > limit_r) || (lo > limit_r);

  assign eff_min = (cnt_r == '0) ? pop_op.meas : min_r;
  assign eff_max = (cnt_r == '0) ? pop_op.meas : max_r;

  always_comb begin
    range_nxt = range_r;
    fail_nxt  = fail_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_wr    = 1'b0;
    case (pop_op.kind)
      sfpv_pkg::OP_REQ: begin
        range_nxt = '0;
        fail_nxt  = 1'b1;
      end
      sfpv_pkg::OP_GOOD: begin
        range_nxt = pop_op.meas;
        fail_nxt  = 1'b0;
        if (win_on) begin
          sum_wr = 1'b1;
          if (cnt_r < WIN) begin
            sum_nxt = sum_r + SW'(pop_op.meas);
            min_nxt = (pop_op.meas < eff_min) ? pop_op.meas : eff_min;
            max_nxt = (pop_op.meas > eff_max) ? pop_op.meas : eff_max;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            fail_nxt = check_fail;
            sum_nxt  = '0;
            min_nxt  = '0;
            max_nxt  = '0;
            cnt_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= sfpv_pkg::SPREAD_RESET;
      range_r     <= '0;
      fail_r      <= 1'b1;
      cnt_r       <= '0;
      sum_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sum_fresh_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      sum_fresh_r <= take && sum_wr;
      if (take) begin
        range_r     <= range_nxt;
        fail_r      <= fail_nxt;
        cnt_r       <= cnt_nxt;
        sum_r       <= sum_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(sum_r) * PW'(RECIP);
    if (take) begin
      send_valid_r <= (pop_op.kind == sfpv_pkg::OP_REQ);
      range_out_r  <= range_nxt;
      fail_out_r   <= fail_nxt;
      done_out_r   <= (pop_op.kind == sfpv_pkg::OP_GOOD) || (pop_op.kind == sfpv_pkg::OP_BAD);
      good_out_r   <= (pop_op.kind == sfpv_pkg::OP_GOOD);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.send_valid  = send_valid_r;
  assign out_ch.send_byte   = send_valid_r ? sfpv_pkg::CMD_BYTE : 8'h00;
  assign out_ch.range_value = range_out_r;
  assign out_ch.fail_flag   = fail_out_r;
  assign out_ch.frame_done  = done_out_r;
  assign out_ch.frame_good  = good_out_r;

endmodule

// ----- rtl/core/sonar_frame_parser_validator_core.sv -----
// sonar_frame_parser_validator_core: top level of the sonar frame parser/validator
// depends on sfpv_pkg, sfpv_if, sfpv_front, sfpv_queue and sfpv_back
//
// in_ch carries one item per transfer: func 1 is a measurement request, func 0 a
// byte from the sensor uart in rx_byte. out_ch returns exactly one result per item:
// the command byte to send (send_valid/send_byte), the current distance, the fail
// flag and whether the byte closed a four-byte frame and if that frame was good.
// cfg_we/cfg_wdata write the spread limit (reset 50, zero turns window checks off).
// An item enters the queue on transfer; the back stage registers its result when
// it takes the item. A good frame that closes a full window, arriving right after
// the window filled, waits for the average from a registered reciprocal multiply
// of the window sum. Otherwise one item is taken per cycle unless out_ch stalls.
// A two-entry queue parts the front from the back and an output register holds the
// result, so while out_ch is stalled up to three items are held before in_ch.ready
// drops. Synchronous reset clears the frame position, the queue, the window and the
// output, loads the spread limit reset value, sets fail and empties the result.

module sonar_frame_parser_validator_core #(
  parameter int WINDOW_SIZE = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sfpv_in_if.sink                      in_ch,
  sfpv_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [sfpv_pkg::RANGE_W-1:0] cfg_wdata
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  sfpv_pkg::op_t push_op, pop_op;

  sfpv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  sfpv_queue #(
    .DEPTH (sfpv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  sfpv_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/core/sfpv_checker.sv -----
// sfpv_checker: port-level assertions for the sonar frame parser/validator core
// depends on sfpv_pkg; bound to sonar_frame_parser_validator_core

module sfpv_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         send_valid,
  input logic [7:0]                   send_byte,
  input logic [sfpv_pkg::RANGE_W-1:0] range_value,
  input logic                         fail_flag,
  input logic                         frame_done,
  input logic                         frame_good
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_valid |->
      send_byte == sfpv_pkg::CMD_BYTE && fail_flag && range_value == '0 && !frame_done)
    else $error("request result inconsistent");

  a_good_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_good |-> frame_done && !send_valid)
    else $error("good frame without frame end");

  a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !send_valid |-> send_byte == 8'h00)
    else $error("command byte without send");

endmodule

bind sonar_frame_parser_validator_core sfpv_checker u_sfpv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .send_valid  (out_ch.send_valid),
  .send_byte   (out_ch.send_byte),
  .range_value (out_ch.range_value),
  .fail_flag   (out_ch.fail_flag),
  .frame_done  (out_ch.frame_done),
  .frame_good  (out_ch.frame_good)
);

// ----- sim/sonar_frame_parser_validator_core_tb.sv -----
// sonar_frame_parser_validator_core_tb: self-checking bench for the sonar frame parser core
// depends on sfpv_pkg, sfpv_if and the core; a directed table, then random frame traffic
// under several spread limits, with bursty input, stalling output and per-field checks

module sonar_frame_parser_validator_core_tb;

  localparam int WINDOW          = 10;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES     = 64;
  localparam int IDLE_LIMIT      = 2000;
  localparam int PRINT_LIMIT     = 50;

  typedef struct packed {
    logic                         send_valid;
    logic [7:0]                   send_byte;
    logic [sfpv_pkg::RANGE_W-1:0] range_value;
    logic                         fail_flag;
    logic                         frame_done;
    logic                         frame_good;
  } sonar_result_t;

  typedef struct packed {
    logic          func;
    logic [7:0]    rx_byte;
    logic          typed;
    sonar_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_EVERY4, SINK_RARE} sink_mode_t;

  localparam sonar_result_t UNCHECKED = '0;
  localparam sonar_result_t ARMED     = '{1'b1, sfpv_pkg::CMD_BYTE, 16'h0000, 1'b1, 1'b0, 1'b0};
  localparam sonar_result_t WAITING   = '{1'b0, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0};

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{1'b1, 8'hA5, 1'b1, ARMED},
    '{1'b1, 8'h5A, 1'b1, WAITING},
    '{1'b0, 8'hFF, 1'b1, WAITING},
    '{1'b0, 8'h00, 1'b1, WAITING},
    '{1'b0, 8'h00, 1'b1, WAITING},
    '{1'b0, 8'hFF, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1}},
    '{1'b1, 8'h00, 1'b1, ARMED},
    '{1'b0, 8'hFF, 1'b0, UNCHECKED},
    '{1'b0, 8'hFF, 1'b0, UNCHECKED},
    '{1'b0, 8'hFF, 1'b0, UNCHECKED},
    '{1'b0, 8'hFD, 1'b1, '{1'b0, 8'h00, 16'hFFFF, 1'b0, 1'b1, 1'b1}},
    '{1'b0, 8'h00, 1'b0, UNCHECKED},
    '{1'b0, 8'h12, 1'b0, UNCHECKED},
    '{1'b0, 8'h34, 1'b0, UNCHECKED},
    '{1'b0, 8'h46, 1'b1, '{1'b0, 8'h00, 16'hFFFF, 1'b0, 1'b1, 1'b0}},
    '{1'b0, 8'hFF, 1'b0, UNCHECKED},
    '{1'b0, 8'h01, 1'b0, UNCHECKED},
    '{1'b0, 8'h02, 1'b0, UNCHECKED},
    '{1'b0, 8'h00, 1'b1, '{1'b0, 8'h00, 16'hFFFF, 1'b0, 1'b1, 1'b0}},
    '{1'b0, 8'hFF, 1'b0, UNCHECKED},
    '{1'b1, 8'hC3, 1'b1, ARMED},
    '{1'b0, 8'h00, 1'b0, UNCHECKED},
    '{1'b0, 8'h10, 1'b0, UNCHECKED},
    '{1'b0, 8'h0F, 1'b1, '{1'b0, 8'h00, 16'h0010, 1'b0, 1'b1, 1'b1}}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [sfpv_pkg::RANGE_W-1:0] cfg_wdata;

  sfpv_in_if  in_ch();
  sfpv_out_if out_ch();

  sonar_frame_parser_validator_core #(
    .WINDOW_SIZE(WINDOW)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // sensor-side state mirrored for prediction
  logic [sfpv_pkg::RANGE_W-1:0] spread_limit_mdl = sfpv_pkg::SPREAD_RESET;
  logic [1:0]                   frame_pos        = '0;
  logic [7:0]                   frame_hold [3]   = '{8'h00, 8'h00, 8'h00};
  logic                         cmd_armed        = 1'b1;
  logic [sfpv_pkg::RANGE_W-1:0] dist_reg         = '0;
  logic                         fail_reg         = 1'b1;
  logic [sfpv_pkg::CNT_W-1:0]   win_cnt          = '0;
  logic [sfpv_pkg::SUM_W-1:0]   win_sum          = '0;
  logic [sfpv_pkg::RANGE_W-1:0] win_min          = '0;
  logic [sfpv_pkg::RANGE_W-1:0] win_max          = '0;

  sonar_result_t expected_results [$];
  stim_row_t     phase_items [$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            burst_left     = 0;
  int            gen_align      = 0;
  int            idle_cycles    = 0;
  bit            hold_pending   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void track_window(logic [sfpv_pkg::RANGE_W-1:0] d);
    logic [sfpv_pkg::SUM_W-1:0] avg;
    logic [sfpv_pkg::SUM_W-1:0] hi_gap;
    logic [sfpv_pkg::SUM_W-1:0] lo_gap;
    if (spread_limit_mdl == '0) return;
    if (win_cnt == '0) begin
      win_min = d;
      win_max = d;
    end
    if (win_cnt < WINDOW) begin
      win_sum = win_sum + sfpv_pkg::SUM_W'(d);
      if (d > win_max) win_max = d;
      if (d < win_min) win_min = d;
      win_cnt = win_cnt + 1'b1;
    end else begin
      avg = sfpv_pkg::SUM_W'(win_sum / WINDOW);
      hi_gap = (win_max >= avg) ? win_max - avg : '0;
      lo_gap = (avg >= win_min) ? avg - win_min : '0;
      fail_reg = (hi_gap > spread_limit_mdl) || (lo_gap > spread_limit_mdl);
      win_max = '0;
      win_min = '0;
      win_cnt = '0;
      win_sum = '0;
    end
  endfunction

  function automatic sonar_result_t sonar_predict(logic func, logic [7:0] b);
    sonar_result_t r;
    logic [7:0]    csum;
    r = '0;
    if (func) begin
      if (cmd_armed) begin
        cmd_armed = 1'b0;
        dist_reg = '0;
        fail_reg = 1'b1;
        r.send_valid = 1'b1;
        r.send_byte = sfpv_pkg::CMD_BYTE;
      end
    end else if (frame_pos != sfpv_pkg::LAST_IDX) begin
      frame_hold[frame_pos] = b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      csum = frame_hold[0] + frame_hold[1] + frame_hold[2];
      r.frame_done = 1'b1;
      if (frame_hold[0] == sfpv_pkg::HDR_BYTE && csum == b) begin
        r.frame_good = 1'b1;
        fail_reg = 1'b0;
        dist_reg = {frame_hold[1], frame_hold[2]};
        track_window(dist_reg);
      end
      frame_pos = '0;
      cmd_armed = 1'b1;
    end
    r.range_value = dist_reg;
    r.fail_flag = fail_reg;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("result %0d %s: got %0h want %0h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    phase_items.push_back('{1'b0, b, 1'b0, UNCHECKED});
    gen_align = (gen_align + 1) % 4;
  endtask

  task automatic push_request();
    phase_items.push_back('{1'b1, 8'($urandom), 1'b0, UNCHECKED});
  endtask

  task automatic put_frame(input logic [7:0] hdr, input logic [7:0] hi, input logic [7:0] lo,
                           input logic [7:0] csum);
    while (gen_align != 0) push_byte(8'($urandom));
    push_byte(hdr);
    if ($urandom_range(0, 11) == 0) push_request();
    push_byte(hi);
    push_byte(lo);
    push_byte(csum);
  endtask

  task automatic plan_phase(input int n_items);
    int                           center;
    int                           span;
    int                           v;
    int                           pick;
    logic [sfpv_pkg::RANGE_W-1:0] d;
    logic [7:0]                   hdr;
    center = $urandom_range(0, 65535);
    while (phase_items.size() < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 9) < 7) push_request();
        case ($urandom_range(0, 19))
          0: d = 16'h0000;
          1: d = 16'hFFFF;
          2: d = 16'($urandom);
          default: begin
            pick = $urandom_range(0, 99);
            span = (pick < 15) ? 0 : (pick < 70) ? 80 : 3000;
            v = $urandom_range(0, span);
            v = (center + v > 65535) ? center - v : center + v;
            d = v[15:0];
          end
        endcase
        put_frame(sfpv_pkg::HDR_BYTE, d[15:8], d[7:0],
                  sfpv_pkg::HDR_BYTE + d[15:8] + d[7:0]);
      end else if (pick < 75) begin
        d = 16'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          hdr = 8'($urandom_range(0, 254));
          put_frame(hdr, d[15:8], d[7:0], hdr + d[15:8] + d[7:0]);
        end else begin
          put_frame(sfpv_pkg::HDR_BYTE, d[15:8], d[7:0],
                    sfpv_pkg::HDR_BYTE + d[15:8] + d[7:0] + 8'($urandom_range(1, 255)));
        end
      end else if (pick < 85) begin
        push_request();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) push_request();
          else push_byte(8'($urandom));
        end
      end
    end
  endtask

  task automatic offer_item(input stim_row_t row);
    int            gap;
    sonar_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.func <= row.func;
    in_ch.rx_byte <= row.rx_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = sonar_predict(row.func, row.rx_byte);
    if (row.typed) want = row.want;
    expected_results.push_back(want);
  endtask

  task automatic settle(input int tail);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_spread_limit(input logic [sfpv_pkg::RANGE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    spread_limit_mdl = value;
  endtask

  initial begin : stimulus
    logic [sfpv_pkg::RANGE_W-1:0] lim;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIRECTED_ROWS[i]) offer_item(DIRECTED_ROWS[i]);
    in_ch.valid <= 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle(4);
      case (phase)
        0:       lim = 16'($urandom_range(20, 200));
        1:       lim = 16'h0000;
        2:       lim = 16'hFFFF;
        3:       lim = 16'h0001;
        default: lim = 16'($urandom);
      endcase
      write_spread_limit(lim);
      if (phase == 2) hold_pending = 1'b1;
      plan_phase(ITEMS_PER_PHASE);
      while (phase_items.size() != 0) offer_item(phase_items.pop_front());
      in_ch.valid <= 1'b0;
    end
    settle(8);
    if (expected_results.size() != 0)
      report_mismatch("results missing", 32'(expected_results.size()), 0);
    if (mismatch_count == 0) begin
      $display("sonar_frame_parser_validator_core regression: pass");
    end else begin
      $display("sonar_frame_parser_validator_core regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    sink_mode_t mode;
    int         left;
    int         tick;
    mode = SINK_OPEN;
    left = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 80);
      end
      left--;
      tick++;
      case (mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_EVERY4: out_ch.ready <= (tick % 4 == 0);
        default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare every output transfer with the oldest expectation
  always @(posedge clk) begin
    sonar_result_t got;
    sonar_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.send_valid, out_ch.send_byte, out_ch.range_value, out_ch.fail_flag,
             out_ch.frame_done, out_ch.frame_good};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.send_valid !== want.send_valid)
          report_mismatch("send_valid", 32'(got.send_valid), 32'(want.send_valid));
        if (got.send_byte !== want.send_byte)
          report_mismatch("send_byte", 32'(got.send_byte), 32'(want.send_byte));
        if (got.range_value !== want.range_value)
          report_mismatch("range_value", 32'(got.range_value), 32'(want.range_value));
        if (got.fail_flag !== want.fail_flag)
          report_mismatch("fail_flag", 32'(got.fail_flag), 32'(want.fail_flag));
        if (got.frame_done !== want.frame_done)
          report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
        if (got.frame_good !== want.frame_good)
          report_mismatch("frame_good", 32'(got.frame_good), 32'(want.frame_good));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("sonar_frame_parser_validator_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/core/sfpv_pkg.sv
rtl/core/sfpv_if.sv
rtl/core/sfpv_front.sv
rtl/core/sfpv_queue.sv
rtl/core/sfpv_back.sv
rtl/core/sonar_frame_parser_validator_core.sv
rtl/core/sfpv_checker.sv
sim/sonar_frame_parser_validator_core_tb.sv
